// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the parser RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define RPS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define RPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rps_pkg.sv =====
// Shared types and constants of the RESP stream parser.
// Depends on nothing; used by rps_out_fifo and resp_stream_parser_unit.
`default_nettype none
package rps_pkg;

    localparam int MAX_DEPTH_DEF = 8;
    localparam int LEN_BITS_DEF  = 32;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    // Event codes.
    localparam logic [2:0] EV_STR_START = 3'd0;
    localparam logic [2:0] EV_CONTENT   = 3'd1;
    localparam logic [2:0] EV_STR_END   = 3'd2;
    localparam logic [2:0] EV_INTEGER   = 3'd3;
    localparam logic [2:0] EV_NULL      = 3'd4;
    localparam logic [2:0] EV_ARRAY     = 3'd5;
    localparam logic [2:0] EV_ERROR     = 3'd6;

    // Value kinds.
    localparam logic [2:0] VK_SIMPLE = 3'd0;
    localparam logic [2:0] VK_ERRSTR = 3'd1;
    localparam logic [2:0] VK_BULK   = 3'd2;
    localparam logic [2:0] VK_INT    = 3'd3;
    localparam logic [2:0] VK_ARRAY  = 3'd4;

    // Parser phases.
    localparam logic [2:0] PH_TYPE  = 3'd0;
    localparam logic [2:0] PH_LINE  = 3'd1;
    localparam logic [2:0] PH_NLEAD = 3'd2;
    localparam logic [2:0] PH_NBODY = 3'd3;
    localparam logic [2:0] PH_BDATA = 3'd4;
    localparam logic [2:0] PH_BCR   = 3'd5;
    localparam logic [2:0] PH_BLF   = 3'd6;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOLL  = 8'h24;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    typedef struct packed {
        logic        last;
        logic        done;
        logic [3:0]  nest;
        logic [63:0] num;
        logic [7:0]  cbyte;
        logic [1:0]  kind;
        logic [2:0]  ev;
    } rps_res_t;

    function automatic rps_res_t mk_res(logic [2:0] ev, logic [2:0] kind, logic [7:0] cbyte,
                                        logic [63:0] num, logic [3:0] nest, logic done);
        rps_res_t r;
        r.ev    = ev;
        r.kind  = kind[1:0];
        r.cbyte = cbyte;
        r.num   = num;
        r.nest  = nest;
        r.done  = done;
        r.last  = 1'b0;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/resp_stream_parser_unit.sv =====
// RESP2 stream parser: one byte per cycle in while s_tready, parse events out.
// Depends on rps_pkg, rps_out_fifo and assert_macros.svh.
//
// Usage: bytes of the stream arrive on the s_ channel, one per request.
// Each byte is parsed in the cycle it is accepted; the zero, one or two
// events it causes go into a four-entry result queue and leave on the m_
// channel, the final event of a byte marked by m_tlast. A byte that causes
// no event (a header character, a CR) produces nothing on the m_ side.
// An event is written into the queue as its byte is accepted. Throughput:
// one byte per cycle; the rate is set by the result queue, which takes a
// byte only while it has room for two events, so a string line with a lone
// CR (two events) costs an extra output transfer.
// When the receiver stalls, the queue fills and s_tready drops once fewer
// than two free entries remain. Reset (aresetn low, synchronous) empties
// the queue, closes all arrays and clears the sticky error. After a
// protocol error every byte yields one error event until reset.
`default_nettype none
`include "assert_macros.svh"
module resp_stream_parser_unit
    import rps_pkg::*;
#(
    parameter int MAX_DEPTH = MAX_DEPTH_DEF,
    parameter int LEN_BITS  = LEN_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // [7:0] content_byte, [71:8] number,
                                        // [75:72] nest_level, [76] message_done
    output logic [4:0]       m_tuser,   // [2:0] event_res, [4:3] string_kind
    output logic             m_tlast    // last
);

    localparam int SW = $clog2(MAX_DEPTH + 1);
    localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam logic [67:0] LIM_POS = {5'd0, 63'h7FFF_FFFF_FFFF_FFFF};
    localparam logic [67:0] LIM_NEG = {4'd0, 1'b1, 63'd0};

    typedef struct packed {
        logic        ok;
        logic [2:0]  ph;
        logic        neg;
        logic [63:0] acc;
        logic        dig;
        logic        skip;
    } num_st_t;

    // One character of a decimal header line.
    function automatic num_st_t num_char(logic [7:0] c, num_st_t s);
        num_st_t     r;
        logic [67:0] t;
        logic        is_sp;
        logic        go;
        r     = s;
        r.ok  = 1'b1;
        is_sp = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        t     = ({4'd0, s.acc} << 3) + ({4'd0, s.acc} << 1) + {60'd0, c - CH_ZERO};
        go    = 1'b1;
        if (s.ph == PH_NLEAD) begin
            if (is_sp) begin
                go = 1'b0;
            end else begin
                r.ph = PH_NBODY;
                if (c == CH_PLUS) begin
                    go = 1'b0;
                end else if (c == CH_MINUS) begin
                    r.neg = 1'b1;
                    go    = 1'b0;
                end
            end
        end else if (s.skip) begin
            go = 1'b0;
        end
        if (go) begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
                if (t > (r.neg ? LIM_NEG : LIM_POS)) begin
                    r.ok = 1'b0;
                end else begin
                    r.acc = t[63:0];
                    r.dig = 1'b1;
                end
            end else if (s.dig) begin
                r.skip = 1'b1;
            end else begin
                r.ok = 1'b0;
            end
        end
        return r;
    endfunction

    logic [2:0]    ph_reg, ph_next;
    logic [2:0]    vk_reg, vk_next;
    logic [63:0]   acc_reg, acc_next;
    logic          neg_reg, neg_next;
    logic          dig_reg, dig_next;
    logic          skip_reg, skip_next;
    logic          cr_reg, cr_next;
    logic [LEN_BITS-1:0] rem_reg, rem_next;
    logic [SW-1:0] lvl_reg, lvl_next;
    logic          err_reg, err_next;

    logic [LEN_BITS-1:0] cnt_mem [MAX_DEPTH];
    logic [MAX_DEPTH-1:0] one_reg;

    logic          acc_fire;
    logic          room_two;
    logic [7:0]    c;
    logic [1:0]    n;
    rps_res_t      res0, res1, out_res, fin0, fin1;
    logic          do_fin, do_push;

    logic          fin_found;
    logic [IW-1:0] fin_idx;
    logic [SW-1:0] fin_lvl;
    logic          fin_done;
    logic [LEN_BITS-1:0] fin_cnt;

    num_st_t       st0, st1, st2;
    logic          cr_first;
    logic [63:0]   val;
    logic          nz_neg;
    logic          oversize;
    logic [3:0]    nest;

    assign c        = s_tdata;
    assign acc_fire = s_tvalid && s_tready;
    assign s_tready = room_two;
    assign nest     = 4'(lvl_reg);

    // Closing one element pops the innermost arrays whose count is down to one.
    always_comb begin
        fin_found = 1'b0;
        fin_idx   = '0;
        for (int i = 0; i < MAX_DEPTH; i++) begin
            if (SW'(i) < lvl_reg && !one_reg[i]) begin
                fin_found = 1'b1;
                fin_idx   = IW'(i);
            end
        end
        fin_lvl  = fin_found ? (SW'(fin_idx) + SW'(1)) : '0;
        fin_done = !fin_found;
    end

    assign fin_cnt  = cnt_mem[fin_idx];
    assign val      = neg_reg ? (64'd0 - acc_reg) : acc_reg;
    assign nz_neg   = neg_reg && (acc_reg != 64'd0);
    assign oversize = (acc_reg[63:LEN_BITS] != '0);

    always_comb begin
        ph_next   = ph_reg;
        vk_next   = vk_reg;
        acc_next  = acc_reg;
        neg_next  = neg_reg;
        dig_next  = dig_reg;
        skip_next = skip_reg;
        cr_next   = cr_reg;
        rem_next  = rem_reg;
        lvl_next  = lvl_reg;
        err_next  = err_reg;
        n         = 2'd0;
        res0      = '0;
        res1      = '0;
        fin0      = '0;
        fin1      = '0;
        do_fin    = 1'b0;
        do_push   = 1'b0;
        cr_first  = cr_reg && (c != CH_LF);
        st0       = {1'b1, ph_reg, neg_reg, acc_reg, dig_reg, skip_reg};
        st1       = cr_first ? num_char(CH_CR, st0) : st0;
        st2       = num_char(c, st1);

        if (err_reg) begin
            res0 = mk_res(EV_ERROR, VK_SIMPLE, 8'd0, 64'd0, nest, 1'b0);
            n    = 2'd1;
        end else begin
            unique case (ph_reg)
                PH_TYPE: begin
                    if (c == CH_PLUS || c == CH_MINUS) begin
                        vk_next = (c == CH_PLUS) ? VK_SIMPLE : VK_ERRSTR;
                        cr_next = 1'b0;
                        ph_next = PH_LINE;
                        res0 = mk_res(EV_STR_START, vk_next, 8'd0, 64'd0, nest, 1'b0);
                        n    = 2'd1;
                    end else if (c == CH_COLON || c == CH_DOLL || c == CH_STAR) begin
                        vk_next   = (c == CH_COLON) ? VK_INT :
                                    (c == CH_DOLL) ? VK_BULK : VK_ARRAY;
                        acc_next  = '0;
                        neg_next  = 1'b0;
                        dig_next  = 1'b0;
                        skip_next = 1'b0;
                        cr_next   = 1'b0;
                        ph_next   = PH_NLEAD;
                    end else begin
                        err_next = 1'b1;
                        res0 = mk_res(EV_ERROR, VK_SIMPLE, 8'd0, 64'd0, nest, 1'b0);
                        n    = 2'd1;
                    end
                end
                PH_LINE: begin
                    cr_next = 1'b0;
                    if (cr_reg && c == CH_LF) begin
                        do_fin   = 1'b1;
                        lvl_next = fin_lvl;
                        ph_next  = PH_TYPE;
                        res0 = mk_res(EV_STR_END, vk_reg, 8'd0, 64'd0, nest, fin_done);
                        n    = 2'd1;
                    end else begin
                        fin0 = mk_res(EV_CONTENT, vk_reg, CH_CR, 64'd0, nest, 1'b0);
                        fin1 = mk_res(EV_CONTENT, vk_reg, c, 64'd0, nest, 1'b0);
                        if (cr_first) begin
                            res0 = fin0;
                            n    = 2'd1;
                        end
                        if (c == CH_CR) begin
                            cr_next = 1'b1;
                        end else if (cr_first) begin
                            res1 = fin1;
                            n    = 2'd2;
                        end else begin
                            res0 = fin1;
                            n    = 2'd1;
                        end
                    end
                end
                PH_NLEAD, PH_NBODY: begin
                    cr_next = 1'b0;
                    if (cr_reg && c == CH_LF) begin
                        ph_next = PH_TYPE;
                        n       = 2'd1;
                        res0 = mk_res(EV_ERROR, VK_SIMPLE, 8'd0, 64'd0, nest, 1'b0);
                        if (!dig_reg) begin
                            err_next = 1'b1;
                        end else if (vk_reg == VK_INT) begin
                            do_fin   = 1'b1;
                            lvl_next = fin_lvl;
                            res0 = mk_res(EV_INTEGER, VK_SIMPLE, 8'd0, val, nest, fin_done);
                        end else if (vk_reg == VK_BULK) begin
                            if (nz_neg && acc_reg == 64'd1) begin
                                do_fin   = 1'b1;
                                lvl_next = fin_lvl;
                                res0 = mk_res(EV_NULL, VK_SIMPLE, 8'd0, val, nest, fin_done);
                            end else if (nz_neg || oversize) begin
                                err_next = 1'b1;
                            end else begin
                                rem_next = acc_reg[LEN_BITS-1:0];
                                ph_next  = (acc_reg == 64'd0) ? PH_BCR : PH_BDATA;
                                res0 = mk_res(EV_STR_START, VK_BULK, 8'd0, val, nest, 1'b0);
                            end
                        end else begin
                            if (nz_neg || oversize) begin
                                err_next = 1'b1;
                            end else if (acc_reg == 64'd0) begin
                                do_fin   = 1'b1;
                                lvl_next = fin_lvl;
                                res0 = mk_res(EV_ARRAY, VK_SIMPLE, 8'd0, 64'd0, nest, fin_done);
                            end else if (lvl_reg >= SW'(MAX_DEPTH)) begin
                                err_next = 1'b1;
                            end else begin
                                do_push  = 1'b1;
                                lvl_next = lvl_reg + SW'(1);
                                res0 = mk_res(EV_ARRAY, VK_SIMPLE, 8'd0, val, nest, 1'b0);
                            end
                        end
                    end else if (!st1.ok || (c != CH_CR && !st2.ok)) begin
                        err_next = 1'b1;
                        ph_next  = PH_TYPE;
                        res0 = mk_res(EV_ERROR, VK_SIMPLE, 8'd0, 64'd0, nest, 1'b0);
                        n    = 2'd1;
                    end else begin
                        if (c == CH_CR) begin
                            cr_next = 1'b1;
                            {ph_next, neg_next, acc_next, dig_next, skip_next} =
                                {st1.ph, st1.neg, st1.acc, st1.dig, st1.skip};
                        end else begin
                            {ph_next, neg_next, acc_next, dig_next, skip_next} =
                                {st2.ph, st2.neg, st2.acc, st2.dig, st2.skip};
                        end
                    end
                end
                PH_BDATA: begin
                    res0 = mk_res(EV_CONTENT, VK_BULK, c, 64'd0, nest, 1'b0);
                    n    = 2'd1;
                    rem_next = rem_reg - LEN_BITS'(1);
                    if (rem_reg == LEN_BITS'(1)) begin
                        ph_next = PH_BCR;
                    end
                end
                PH_BCR: begin
                    if (c == CH_CR) begin
                        ph_next = PH_BLF;
                    end else begin
                        err_next = 1'b1;
                        ph_next  = PH_TYPE;
                        cr_next  = 1'b0;
                        res0 = mk_res(EV_ERROR, VK_SIMPLE, 8'd0, 64'd0, nest, 1'b0);
                        n    = 2'd1;
                    end
                end
                PH_BLF: begin
                    ph_next = PH_TYPE;
                    n       = 2'd1;
                    if (c == CH_LF) begin
                        do_fin   = 1'b1;
                        lvl_next = fin_lvl;
                        res0 = mk_res(EV_STR_END, vk_reg, 8'd0, 64'd0, nest, fin_done);
                    end else begin
                        err_next = 1'b1;
                        cr_next  = 1'b0;
                        res0 = mk_res(EV_ERROR, VK_SIMPLE, 8'd0, 64'd0, nest, 1'b0);
                    end
                end
                default: begin
                    err_next = 1'b1;
                    ph_next  = PH_TYPE;
                    cr_next  = 1'b0;
                    res0 = mk_res(EV_ERROR, VK_SIMPLE, 8'd0, 64'd0, nest, 1'b0);
                    n    = 2'd1;
                end
            endcase
        end

        if (n == 2'd1) begin
            res0.last = 1'b1;
        end
        res1.last = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (acc_fire && do_push) begin
            cnt_mem[lvl_reg[IW-1:0]] <= acc_reg[LEN_BITS-1:0];
            one_reg[lvl_reg[IW-1:0]] <= (acc_reg == 64'd1);
        end else if (acc_fire && do_fin && fin_found) begin
            cnt_mem[fin_idx] <= fin_cnt - LEN_BITS'(1);
            one_reg[fin_idx] <= (fin_cnt == LEN_BITS'(2));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg   <= PH_TYPE;
            vk_reg   <= VK_SIMPLE;
            acc_reg  <= '0;
            neg_reg  <= 1'b0;
            dig_reg  <= 1'b0;
            skip_reg <= 1'b0;
            cr_reg   <= 1'b0;
            rem_reg  <= '0;
            lvl_reg  <= '0;
            err_reg  <= 1'b0;
        end else if (acc_fire) begin
            ph_reg   <= ph_next;
            vk_reg   <= vk_next;
            acc_reg  <= acc_next;
            neg_reg  <= neg_next;
            dig_reg  <= dig_next;
            skip_reg <= skip_next;
            cr_reg   <= cr_next;
            rem_reg  <= rem_next;
            lvl_reg  <= lvl_next;
            err_reg  <= err_next;
        end
    end

    rps_out_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_n    (acc_fire ? n : 2'd0),
        .push0     (res0),
        .push1     (res1),
        .room_two  (room_two),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .out_ready (m_tready)
    );

    assign m_tdata = {3'd0, out_res.done, out_res.nest, out_res.num, out_res.cbyte};
    assign m_tuser = {out_res.kind, out_res.ev};
    assign m_tlast = out_res.last;

    `RPS_ASSERT_NEXT(a_err_sticky, aclk, aresetn, err_reg, err_reg, "sticky error cleared")
    `RPS_ASSERT(a_lvl_bound, aclk, aresetn, lvl_reg <= SW'(MAX_DEPTH), "array stack overrun")
    `RPS_ASSERT_NEXT(a_err_event, aclk, aresetn, acc_fire && err_reg, m_tvalid, "error lost")
    `RPS_ASSERT(a_bulk_cnt, aclk, aresetn, (ph_reg != PH_BDATA) || (rem_reg != '0), "bulk count zero")

endmodule
`default_nettype wire

// ===== rtl/rps_out_fifo.sv =====
// Small result queue that takes up to two events per cycle and gives one.
// Depends on rps_pkg.
`default_nettype none
module rps_out_fifo
    import rps_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic [1:0] push_n,
    input  wire rps_res_t push0,
    input  wire rps_res_t push1,
    output logic          room_two,
    output logic          out_valid,
    output rps_res_t      out_data,
    input  wire logic     out_ready
);

    rps_res_t mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_reg, rd_reg;
    logic [FIFO_AW:0]   cnt_reg, cnt_next;
    logic               pop;

    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem_reg[rd_reg];
    assign pop       = out_valid && out_ready;
    assign room_two  = (cnt_reg <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign cnt_next  = cnt_reg + (FIFO_AW+1)'(push_n) - (FIFO_AW+1)'(pop);

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            mem_reg[wr_reg] <= push0;
        end
        if (push_n == 2'd2) begin
            mem_reg[wr_reg + FIFO_AW'(1)] <= push1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_reg + FIFO_AW'(push_n);
            rd_reg  <= rd_reg + FIFO_AW'(pop);
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire
